[design/swrsp_pkg.sv]
// ----------------------------------------------------------------------------
// swrsp_pkg: shared types and constants for the LIFO stack unit
// Command and status codes, beat payload structs and the underflow word.
// ----------------------------------------------------------------------------
package swrsp_pkg;

    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 6;

    // value returned by a pop on an empty stack
    localparam logic signed [DATA_W-1:0] UNDERFLOW_WORD = -32'sd999;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH        = 2'd0,
        CMD_POP         = 2'd1,
        CMD_REVERSE     = 2'd2,
        CMD_SORTED_PUSH = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] operand;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        t_status                  status;
        logic [DEPTH_OUT_W-1:0]   depth_after;
    } t_rsp;

endpackage

[design/swrsp_cmd_if.sv]
// ----------------------------------------------------------------------------
// swrsp_cmd_if: command channel
// Valid/ready channel carrying one stack command and its operand per beat.
// ----------------------------------------------------------------------------
interface swrsp_cmd_if;

    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] operand;

    modport source (output valid, output cmd, output operand, input ready);
    modport sink   (input valid, input cmd, input operand, output ready);

endinterface

[design/swrsp_res_if.sv]
// ----------------------------------------------------------------------------
// swrsp_res_if: result channel
// Valid/ready channel carrying data, status and depth for each command.
// ----------------------------------------------------------------------------
interface swrsp_res_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [5:0]         depth_after;

    modport source (output valid, output data_out, output status, output depth_after,
                    input ready);
    modport sink   (input valid, input data_out, input status, input depth_after,
                    output ready);

endinterface

[design/swrsp_core.sv]
// ----------------------------------------------------------------------------
// swrsp_core: stack storage and combinational command update
// Circular register file with base pointer and direction bit; reverse flips
// the direction, sorted push shifts the run above the insert point by one.
// ----------------------------------------------------------------------------
module swrsp_core #(
    parameter int DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  swrsp_pkg::t_req i_req,
    output swrsp_pkg::t_rsp o_rsp
);
    import swrsp_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_base, n_base;
    logic                     r_dir, n_dir;

    logic [LW-1:0]    count_l;
    logic             full;
    logic [IW-1:0]    top_slot;
    logic [DEPTH-1:0] stop_phys;
    logic [DEPTH-1:0] rot [IW+1];
    logic [LW-1:0]    run_lo;
    logic [LW-1:0]    ins_at;
    logic             ins_en;

    // physical slot of logical position off
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [LW-1:0] off,
                                             input logic          dir);
        logic [LW-1:0] s;
        if (!dir) begin
            s = LW'(base) + off;
            if (s >= LW'(DEPTH)) begin
                s = s - LW'(DEPTH);
            end
        end else if (LW'(base) >= off) begin
            s = LW'(base) - off;
        end else begin
            s = LW'(base) + LW'(DEPTH) - off;
        end
        return s[IW-1:0];
    endfunction

    assign count_l  = LW'(r_count);
    assign full     = (r_count == CW'(DEPTH));
    assign top_slot = f_slot(r_base, count_l - LW'(1), r_dir);

    // per-slot logical position, stop flag and shift/insert write
    for (genvar p = 0; p < DEPTH; p++) begin : g_slot
        localparam int P_DN = (p == 0) ? DEPTH - 1 : p - 1;
        localparam int P_UP = (p == DEPTH - 1) ? 0 : p + 1;

        logic [LW-1:0] pos;
        logic          held;

        always_comb begin
            if (!r_dir) begin
                pos = (LW'(p) >= LW'(r_base)) ? LW'(p) - LW'(r_base)
                                              : LW'(p) + LW'(DEPTH) - LW'(r_base);
            end else begin
                pos = (LW'(r_base) >= LW'(p)) ? LW'(r_base) - LW'(p)
                                              : LW'(r_base) + LW'(DEPTH) - LW'(p);
            end
        end

        assign held         = (pos < count_l);
        // entry that is not greater than the operand ends the run
        assign stop_phys[p] = held && !(r_mem[p] > i_req.operand);

        always_ff @(posedge i_clk) begin
            if (ins_en) begin
                if (pos == ins_at) begin
                    r_mem[p] <= i_req.operand;
                end else if (pos > ins_at && pos <= count_l) begin
                    r_mem[p] <= r_dir ? r_mem[P_UP] : r_mem[P_DN];
                end
            end
        end
    end

    // rotate stop flags into logical order: reflect for reversed, then barrel by base
    for (genvar m = 0; m < DEPTH; m++) begin : g_refl
        localparam int SRC = (m == 0) ? 0 : DEPTH - m;
        assign rot[0][m] = r_dir ? stop_phys[SRC] : stop_phys[m];
    end

    for (genvar s = 0; s < IW; s++) begin : g_rot
        localparam int AMT = (1 << s) % DEPTH;
        for (genvar m = 0; m < DEPTH; m++) begin : g_bit
            localparam int FWD = (m + AMT) % DEPTH;
            localparam int BWD = (m + DEPTH - AMT) % DEPTH;
            assign rot[s+1][m] = !r_base[s] ? rot[s][m]
                               : (r_dir ? rot[s][BWD] : rot[s][FWD]);
        end
    end

    // insert point: just above the highest stopping entry
    always_comb begin
        run_lo = '0;
        for (int l = 0; l < DEPTH; l++) begin
            if (rot[IW][l]) begin
                run_lo = LW'(l + 1);
            end
        end
    end

    assign ins_at = (i_req.cmd == CMD_PUSH) ? count_l : run_lo;
    assign ins_en = i_fire && !full
                    && (i_req.cmd == CMD_PUSH || i_req.cmd == CMD_SORTED_PUSH);

    always_comb begin
        n_count        = r_count;
        n_base         = r_base;
        n_dir          = r_dir;
        o_rsp.data_out = '0;
        o_rsp.status   = ST_OK;
        case (i_req.cmd)
            CMD_PUSH, CMD_SORTED_PUSH: begin
                if (full) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    o_rsp.data_out = UNDERFLOW_WORD;
                    o_rsp.status   = ST_UNDERFLOW;
                end else begin
                    n_count        = r_count - CW'(1);
                    o_rsp.data_out = r_mem[top_slot];
                end
            end
            CMD_REVERSE: begin
                if (r_count > CW'(1)) begin
                    n_base = top_slot;
                    n_dir  = !r_dir;
                end
            end
            default: begin
            end
        endcase
        o_rsp.depth_after = DEPTH_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_base  <= '0;
            r_dir   <= 1'b0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_base  <= n_base;
            r_dir   <= n_dir;
        end
    end

endmodule

[design/stack_with_reverse_and_sorted_push_unit.sv]
// ----------------------------------------------------------------------------
// stack_with_reverse_and_sorted_push_unit: bounded LIFO stack, one command/beat
// Push, pop, whole-stack reverse and sorted push on signed 32-bit words.
// ----------------------------------------------------------------------------
// Result path: the command register feeds the combinational update, and the
//   result register loads from it whenever the result stage can advance.
// Throughput: one command per cycle unless the result channel stalls; the
//   whole stack update is combinational between the two registers.
// Reset (i_rst_n low, synchronous): stack empty, both channel stages empty.
//   Entry storage is not cleared; only slots below the fill count are read.
// ----------------------------------------------------------------------------
module stack_with_reverse_and_sorted_push_unit #(
    parameter int DEPTH = 32
) (
    input logic           i_clk,
    input logic           i_rst_n,
    swrsp_cmd_if.sink     i_cmd_ch,
    swrsp_res_if.source   o_res_ch
);
    import swrsp_pkg::*;

    // command register
    logic r_in_valid;
    t_req r_in_req;

    // result register
    logic r_out_valid;
    t_rsp r_out_rsp;

    t_rsp core_rsp;
    logic advance;   // result register free to take a new beat
    logic fire;      // command in the register is executed this cycle
    logic in_ready;

    assign advance  = !r_out_valid || o_res_ch.ready;
    assign fire     = r_in_valid && advance;
    // command stage refills in the same cycle it drains
    assign in_ready = !r_in_valid || advance;

    assign i_cmd_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_cmd_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd_ch.valid) begin
            r_in_req.cmd     <= t_cmd'(i_cmd_ch.cmd);
            r_in_req.operand <= i_cmd_ch.operand;
        end
    end

    // stack state and the combinational update for the registered command
    swrsp_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result is held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_res_ch.valid       = r_out_valid;
    assign o_res_ch.data_out    = r_out_rsp.data_out;
    assign o_res_ch.status      = r_out_rsp.status;
    assign o_res_ch.depth_after = r_out_rsp.depth_after;

endmodule

[design/swrsp_check.sv]
// ----------------------------------------------------------------------------
// swrsp_check: port-level checks for the stack unit
// Result stability under stall and consistency of the status codes.
// ----------------------------------------------------------------------------
module swrsp_check #(
    parameter int DEPTH = 32
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_data_out,
    input logic [1:0]         i_status,
    input logic [5:0]         i_depth_after
);
    import swrsp_pkg::*;

    localparam logic [DEPTH_OUT_W-1:0] FULL_DEPTH = DEPTH_OUT_W'(DEPTH);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_out)
            && $stable(i_status) && $stable(i_depth_after))
        else $error("result changed while stalled");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_UNDERFLOW |->
            i_data_out == UNDERFLOW_WORD && i_depth_after == '0)
        else $error("underflow beat with wrong data or depth");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |->
            i_data_out == '0 && i_depth_after == FULL_DEPTH)
        else $error("dropped push with wrong data or depth");

endmodule

bind stack_with_reverse_and_sorted_push_unit swrsp_check #(
    .DEPTH (DEPTH)
) u_swrsp_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res_ch.valid),
    .i_out_ready   (o_res_ch.ready),
    .i_data_out    (o_res_ch.data_out),
    .i_status      (o_res_ch.status),
    .i_depth_after (o_res_ch.depth_after)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded LIFO stack unit
// Drives push, pop, reverse and sorted-push beats with bursty gaps, stalls the
// result channel on a rolling pattern and checks every result beat against
// a shadow stack that is updated as each command beat is accepted.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swrsp_pkg::*;

    localparam int DEPTH      = 32;
    localparam int IDLE_LIMIT = 1000;   // cycles with no beat on either channel
    localparam int DRAIN_WAIT = 8;      // slack for a stray extra result after the drain
    localparam int RAND_ITEMS = 500;

    // traffic mix of one random segment
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swrsp_cmd_if cmd_ch ();
    swrsp_res_if res_ch ();

    stack_with_reverse_and_sorted_push_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd_ch(cmd_ch),
        .o_res_ch(res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow stack: slot 0 is the bottom, only slots below stk_fill are valid
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] stk_mem [DEPTH];
    int                       stk_fill = 0;

    t_req cmd_backlog [$];      // commands not yet driven
    t_rsp rsp_due [$];          // results owed by the DUT, oldest first
    int   fail_count = 0;

    // Apply one command to the shadow stack and return the result it owes.
    function automatic t_rsp stack_apply(input t_cmd op, input logic signed [DATA_W-1:0] val);
        t_rsp                     r;
        int                       k;
        int                       i;
        logic signed [DATA_W-1:0] tmp;
        r.data_out = '0;
        r.status   = ST_OK;
        case (op)
            CMD_PUSH: begin
                if (stk_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stk_mem[stk_fill] = val;
                    stk_fill++;
                end
            end
            CMD_POP: begin
                if (stk_fill == 0) begin
                    r.data_out = UNDERFLOW_WORD;
                    r.status   = ST_UNDERFLOW;
                end else begin
                    stk_fill--;
                    r.data_out = stk_mem[stk_fill];
                end
            end
            CMD_REVERSE: begin
                // swap pairs from both ends; 0 or 1 entries leaves things alone
                for (k = 0; k < stk_fill / 2; k++) begin
                    tmp                      = stk_mem[k];
                    stk_mem[k]               = stk_mem[stk_fill - 1 - k];
                    stk_mem[stk_fill - 1 - k] = tmp;
                end
            end
            CMD_SORTED_PUSH: begin
                if (stk_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // lift the run of strictly greater entries off the top,
                    // an equal entry stops the run (signed compare)
                    k = stk_fill;
                    while (k > 0 && stk_mem[k - 1] > val)
                        k--;
                    for (i = stk_fill; i > k; i--)
                        stk_mem[i] = stk_mem[i - 1];
                    stk_mem[k] = val;
                    stk_fill++;
                end
            end
            default: ;
        endcase
        r.depth_after = DEPTH_OUT_W'(stk_fill);
        return r;
    endfunction

    task automatic queue_cmd(input t_cmd op, input logic signed [DATA_W-1:0] val);
        t_req q;
        q.cmd     = op;
        q.operand = val;
        cmd_backlog.push_back(q);
    endtask

    // ------------------------------------------------------------------------
    // Command driver: bursts of random length with random gaps in between
    // ------------------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge i_clk) begin : cmd_drive
        t_req nxt;
        if (i_rst_n) begin
            // a new beat may be presented once the previous one is gone
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (gap_left > 0) begin
                    cmd_ch.valid <= 1'b0;
                    gap_left--;
                end else if (cmd_backlog.size() > 0) begin
                    nxt = cmd_backlog.pop_front();
                    cmd_ch.valid   <= 1'b1;
                    cmd_ch.cmd     <= nxt.cmd;
                    cmd_ch.operand <= nxt.operand;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // now and then a long back-to-back stretch
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end else begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.cmd     <= CMD_PUSH;
            cmd_ch.operand <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: ready follows a 16-bit pattern, reloaded every lap.
    // Pattern bit 0 is always set so ready is raised at least once per lap.
    // ------------------------------------------------------------------------
    logic [15:0] rdy_pat = 16'hFFFF;
    logic [3:0]  rdy_idx = 4'd0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            res_ch.ready <= rdy_pat[rdy_idx];
            rdy_idx      <= rdy_idx + 4'd1;
            if (rdy_idx == 4'd15) begin
                case ($urandom_range(0, 3))
                    0:       rdy_pat <= 16'hFFFF;                       // no stalls
                    1:       rdy_pat <= 16'($urandom & $urandom) | 16'h1; // mostly stalled
                    default: rdy_pat <= 16'($urandom) | 16'h1;
                endcase
            end
        end else begin
            res_ch.ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted command beat, check every result beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_rsp want;
        if (i_rst_n) begin
            // predict first, so a same-edge result would still find its entry
            if (cmd_ch.valid && cmd_ch.ready)
                rsp_due.push_back(stack_apply(t_cmd'(cmd_ch.cmd), cmd_ch.operand));
            if (res_ch.valid && res_ch.ready) begin
                if (rsp_due.size() == 0) begin
                    $error("result beat with nothing owed: data_out %0d status %0d depth %0d",
                           res_ch.data_out, res_ch.status, res_ch.depth_after);
                    fail_count++;
                end else begin
                    want = rsp_due.pop_front();
                    if (res_ch.data_out !== want.data_out) begin
                        $error("data_out: expected %0d actual %0d",
                               want.data_out, res_ch.data_out);
                        fail_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d actual %0d",
                               want.status, res_ch.status);
                        fail_count++;
                    end
                    if (res_ch.depth_after !== want.depth_after) begin
                        $error("depth_after: expected %0d actual %0d",
                               want.depth_after, res_ch.depth_after);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stim
        t_mix                     mix;
        int                       seg_len;
        int                       pick;
        int                       j;
        t_cmd                     op;
        logic signed [DATA_W-1:0] val;

        // directed: empty-stack cases, value extremes, sorted-push ordering
        queue_cmd(CMD_POP,         32'sd7);             // underflow
        queue_cmd(CMD_REVERSE,     32'sd0);             // reverse of empty
        queue_cmd(CMD_PUSH,        32'sh7FFFFFFF);
        queue_cmd(CMD_REVERSE,     -32'sd1);            // reverse of one entry
        queue_cmd(CMD_PUSH,        32'sh80000000);
        queue_cmd(CMD_PUSH,        -32'sd1);
        queue_cmd(CMD_PUSH,        32'sd0);
        queue_cmd(CMD_SORTED_PUSH, 32'sd0);             // equal entry stops the run
        queue_cmd(CMD_SORTED_PUSH, -32'sd2);            // slides under 0, 0, -1
        queue_cmd(CMD_SORTED_PUSH, 32'sh80000000);      // stops on the equal 0x80000000 entry near the bottom
        queue_cmd(CMD_SORTED_PUSH, 32'sh7FFFFFFF);      // lands on top
        queue_cmd(CMD_PUSH,        32'shAAAAAAAA);
        queue_cmd(CMD_PUSH,        32'sh55555555);
        queue_cmd(CMD_REVERSE,     32'sh7FFFFFFF);
        for (j = 0; j < 11; j++)
            queue_cmd(CMD_POP, 32'($urandom));          // drains and underflows once

        // random: segments that lean towards filling, draining or neither,
        // so the stack swings between empty and full
        j = 0;
        while (j < RAND_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 2));
            seg_len = (mix == MIX_FILL) ? $urandom_range(40, 80) : $urandom_range(20, 60);
            repeat (seg_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    op = CMD_REVERSE;
                else if ((mix == MIX_FILL  && pick < 20) ||
                         (mix == MIX_DRAIN && pick < 75) ||
                         (mix == MIX_EVEN  && pick < 50))
                    op = CMD_POP;
                else
                    op = ($urandom_range(0, 1) == 0) ? CMD_PUSH : CMD_SORTED_PUSH;
                case ($urandom_range(0, 9))
                    0:       val = 32'sh80000000;
                    1:       val = 32'sh7FFFFFFF;
                    2, 3:    val = 32'($urandom_range(0, 8)) - 32'sd4;   // many ties
                    default: val = 32'($urandom);
                endcase
                queue_cmd(op, val);
                j++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, then everything owed has come back
        while (cmd_backlog.size() > 0 || cmd_ch.valid)
            @(posedge i_clk);
        while (rsp_due.size() > 0)
            @(posedge i_clk);
        // let any stray extra result show itself
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
